// File: rtl/core/hrlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request line path decoder: shared definitions
// Character codes, status codes and the default path name used by the
// request line decoder.
// ----------------------------------------------------------------------------
package hrlpd_pkg;

   // Character codes.
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_UPPER_G = 8'h47;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FORBIDDEN = 2'd1;
   localparam logic [1:0] STATUS_BAD_METHOD = 2'd2;

   // Byte position bookkeeping: saturates once the path has started.
   localparam logic [2:0] POS_METHOD_END = 3'd4;
   localparam logic [2:0] POS_PATH_START = 3'd5;
   localparam logic [2:0] POS_SATURATED  = 3'd6;
   localparam logic [2:0] POS_SHORT_LINE = 3'd3;

   // Escape decoder phases.
   localparam logic [1:0] PHASE_PLAIN   = 2'd0;
   localparam logic [1:0] PHASE_PERCENT = 2'd1;
   localparam logic [1:0] PHASE_HELD    = 2'd2;

   // Default path name for an empty path.
   localparam logic [3:0] DEFAULT_PATH_LAST = 4'd9;

   typedef logic [3:0] name_index_type;

   // Expected method byte at positions 0 to 3.
   function automatic logic [7:0] method_char(input logic upper, input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0:    ch = upper ? 8'h47 : 8'h67;
         2'd1:    ch = upper ? 8'h45 : 8'h65;
         2'd2:    ch = upper ? 8'h54 : 8'h74;
         default: ch = CHAR_SPACE;
      endcase
      return ch;
   endfunction

   // Characters of "index.html".
   function automatic logic [7:0] default_path_char(input name_index_type idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h69;
         4'd1:    ch = 8'h6E;
         4'd2:    ch = 8'h64;
         4'd3:    ch = 8'h65;
         4'd4:    ch = 8'h78;
         4'd5:    ch = 8'h2E;
         4'd6:    ch = 8'h68;
         4'd7:    ch = 8'h74;
         4'd8:    ch = 8'h6D;
         4'd9:    ch = 8'h6C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Hex digit value: digits give c - 48, other bytes lowercase(c) - 87,
   // all modulo 256.
   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c - 8'd48;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = c + 8'd32 - 8'd87;
      end else begin
         v = c - 8'd87;
      end
      return v;
   endfunction

endpackage

// File: rtl/core/http_request_line_path_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request line path decoder
// Checks the method of a request line, scans for dot pairs and emits the
// percent-decoded path one byte per result transaction, with a final status.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req_     in         req_valid/req_stall  line_byte[7:0], line_end
//  rsp_     out        rsp_valid/rsp_stall  path_byte[7:0], byte_valid,
//                                           done_res, status[1:0]
//
// One request byte is taken every cycle unless stalled; its result, if any,
// is registered and appears on the next cycle. A space at byte five expands
// to the ten bytes of "index.html" unless a space at byte four has already
// ended the dot scan; the expansion occupies the result register for ten
// result transactions and the input is stalled until its last byte is taken.
// Reset is synchronous and returns the decoder to the start of a line.
// A stalled result holds its register; the input then stalls in the same cycle.
// ----------------------------------------------------------------------------
module http_request_line_path_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_path_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status
);
   import hrlpd_pkg::*;

   // Line decoder state.
   logic [2:0] pos_ff, pos_in;
   logic       method_ok_ff, method_ok_in;
   logic       upper_ff, upper_in;
   logic       prev_dot_ff, prev_dot_in;
   logic       forbidden_ff, forbidden_in;
   logic       scan_done_ff, scan_done_in;
   logic       closed_ff, closed_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   // Result register.
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_bvalid_ff, out_bvalid_in;
   logic           out_done_ff, out_done_in;
   logic [1:0]     out_status_ff, out_status_in;
   logic           burst_ff, burst_in;
   name_index_type cnt_ff, cnt_in;

   logic       req_fire, rsp_fire, last_beat;
   logic       emit, expand;
   logic [7:0] emit_byte;
   logic       path_active;
   logic [7:0] expected;
   logic [1:0] final_status;
   logic [7:0] held_nibble;
   logic [7:0] line_nibble;
   logic [7:0] merged;

   // Output handshake and input back-pressure.
   assign last_beat = !burst_ff || (cnt_ff == DEFAULT_PATH_LAST);
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign req_stall = out_valid_ff && !(rsp_fire && last_beat);
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_path_byte  = burst_ff ? default_path_char(cnt_ff) : out_byte_ff;
   assign rsp_byte_valid = burst_ff | out_bvalid_ff;
   assign rsp_done_res   = out_done_ff && last_beat;
   assign rsp_status     = rsp_done_res ? out_status_ff : STATUS_OK;

   // Escape merge: the held character gives the upper nibble.
   assign held_nibble = hex_value(held_ff);
   assign line_nibble = hex_value(req_line_byte);
   assign merged      = {held_nibble[3:0], 4'h0} | line_nibble;

   // Per-byte decode of the request line.
   always_comb begin
      pos_in       = (pos_ff < POS_SATURATED) ? pos_ff + 3'd1 : pos_ff;
      method_ok_in = method_ok_ff;
      upper_in     = upper_ff;
      prev_dot_in  = prev_dot_ff;
      forbidden_in = forbidden_ff;
      scan_done_in = scan_done_ff;
      closed_in    = closed_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      emit         = 1'b0;
      emit_byte    = req_line_byte;
      expand       = 1'b0;
      expected     = 8'h00;

      // Method check over bytes zero to three.
      if (pos_ff < POS_METHOD_END) begin
         if (pos_ff == 3'd0) begin
            upper_in = (req_line_byte == CHAR_UPPER_G);
         end
         expected = method_char(upper_in, pos_ff[1:0]);
         if (req_line_byte != expected) begin
            method_ok_in = 1'b0;
         end
      end else if (!scan_done_ff) begin
         // Dot pair scan, stopped by a space or the first pair.
         if (req_line_byte == CHAR_SPACE) begin
            scan_done_in = 1'b1;
         end else if (req_line_byte == CHAR_DOT && prev_dot_ff) begin
            forbidden_in = 1'b1;
            scan_done_in = 1'b1;
         end
         prev_dot_in = (req_line_byte == CHAR_DOT);
      end

      // Path decode with percent escapes.
      path_active = (pos_ff >= POS_PATH_START) && !closed_ff;
      if (path_active) begin
         priority if (req_line_byte == CHAR_SPACE || req_line_byte == CHAR_NUL) begin
            if (phase_ff == PHASE_HELD) begin
               emit      = (held_ff != CHAR_PERCENT);
               emit_byte = (held_ff == CHAR_PLUS) ? CHAR_SPACE : held_ff;
            end
            phase_in  = PHASE_PLAIN;
            closed_in = 1'b1;
            expand    = (req_line_byte == CHAR_SPACE) && (pos_ff == POS_PATH_START)
                        && !scan_done_ff;
         end else if (phase_ff == PHASE_PLAIN) begin
            if (req_line_byte == CHAR_PERCENT) begin
               phase_in = PHASE_PERCENT;
            end else begin
               emit      = 1'b1;
               emit_byte = (req_line_byte == CHAR_PLUS) ? CHAR_SPACE : req_line_byte;
            end
         end else if (phase_ff == PHASE_PERCENT) begin
            held_in  = req_line_byte;
            phase_in = PHASE_HELD;
         end else begin
            emit      = 1'b1;
            emit_byte = merged;
            phase_in  = PHASE_PLAIN;
         end
         // A line ending with one escape character pending passes it plainly.
         if (req_line_end && !closed_in && phase_in == PHASE_HELD) begin
            emit      = (req_line_byte != CHAR_PERCENT);
            emit_byte = (req_line_byte == CHAR_PLUS) ? CHAR_SPACE : req_line_byte;
         end
      end

      // Final status of the line.
      if (req_line_end && pos_ff < POS_SHORT_LINE) begin
         method_ok_in = 1'b0;
      end
      if (!method_ok_in) begin
         final_status = STATUS_BAD_METHOD;
      end else if (forbidden_in) begin
         final_status = STATUS_FORBIDDEN;
      end else begin
         final_status = STATUS_OK;
      end

      // The last byte of a line returns the decoder to its start.
      if (req_line_end) begin
         pos_in       = 3'd0;
         method_ok_in = 1'b1;
         upper_in     = 1'b0;
         prev_dot_in  = 1'b0;
         forbidden_in = 1'b0;
         scan_done_in = 1'b0;
         closed_in    = 1'b0;
         phase_in     = PHASE_PLAIN;
         held_in      = 8'h00;
      end
   end

   // Next contents of the result register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_done_in   = out_done_ff;
      out_status_in = out_status_ff;
      burst_in      = burst_ff;
      cnt_in        = cnt_ff;
      if (req_fire && (emit || expand || req_line_end)) begin
         out_valid_in  = 1'b1;
         out_byte_in   = emit ? emit_byte : 8'h00;
         out_bvalid_in = emit;
         out_done_in   = req_line_end;
         out_status_in = req_line_end ? final_status : STATUS_OK;
         burst_in      = expand;
         cnt_in        = '0;
      end else if (rsp_fire) begin
         if (!last_beat) begin
            cnt_in = cnt_ff + 4'd1;
         end else begin
            out_valid_in = 1'b0;
            burst_in     = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         method_ok_ff <= 1'b1;
         upper_ff     <= 1'b0;
         prev_dot_ff  <= 1'b0;
         forbidden_ff <= 1'b0;
         scan_done_ff <= 1'b0;
         closed_ff    <= 1'b0;
         phase_ff     <= PHASE_PLAIN;
         held_ff      <= 8'h00;
         out_valid_ff <= 1'b0;
         burst_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (req_fire) begin
            pos_ff       <= pos_in;
            method_ok_ff <= method_ok_in;
            upper_ff     <= upper_in;
            prev_dot_ff  <= prev_dot_in;
            forbidden_ff <= forbidden_in;
            scan_done_ff <= scan_done_in;
            closed_ff    <= closed_in;
            phase_ff     <= phase_in;
            held_ff      <= held_in;
         end
         out_valid_ff <= out_valid_in;
         burst_ff     <= burst_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_done_ff   <= out_done_in;
      out_status_ff <= out_status_in;
   end

endmodule
